[rtl/ccfc_pkg.sv]
package ccfc_pkg;

  localparam int unsigned MAX_WIDTH_BYTES = 4;

  localparam logic [7:0]  BYTE_MASK     = 8'hFF;
  localparam logic [2:0]  WIDTH_RESET   = 3'd2;
  localparam logic [31:0] POLY_RESET    = 32'h0000_8005;

  typedef enum logic [1:0] {
    REG_WIDTH_BYTES = 2'd0,
    REG_POLYNOMIAL  = 2'd1,
    REG_REFLECT_IN  = 2'd2,
    REG_REFLECT_OUT = 2'd3
  } cfg_reg_t;

  // Clamp the configured width into 1..MAX_WIDTH_BYTES.
  function automatic logic [2:0] eff_width(logic [2:0] wb);
    logic [2:0] w;
    w = wb;
    if (w == 3'd0) begin
      w = 3'd1;
    end
    if (w > 3'(MAX_WIDTH_BYTES)) begin
      w = 3'(MAX_WIDTH_BYTES);
    end
    return w;
  endfunction

  function automatic logic [31:0] width_mask(logic [2:0] w);
    logic [31:0] m;
    case (w)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Shift that moves a right-aligned CRC of w bytes to the top of 32 bits.
  function automatic logic [4:0] align_shift(logic [2:0] w);
    logic [4:0] s;
    case (w)
      3'd1:    s = 5'd24;
      3'd2:    s = 5'd16;
      3'd3:    s = 5'd8;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] rev8(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  function automatic logic [31:0] rev32(logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  // One byte of MSB-first polynomial division, done left aligned so that
  // every width shares the same eight XOR steps.
  function automatic logic [31:0] div_byte(logic [31:0] crc, logic [7:0] b, logic [2:0] w,
                                           logic [31:0] poly, logic refl);
    logic [31:0] mask;
    logic [31:0] a;
    logic [31:0] p;
    logic [4:0]  sh;
    logic [7:0]  bb;
    mask = width_mask(w);
    sh   = align_shift(w);
    bb   = refl ? rev8(b) : b;
    a    = ((crc & mask) << sh) ^ {bb, 24'h000000};
    p    = (poly & mask) << sh;
    for (int i = 0; i < 8; i++) begin
      if (a[31]) begin
        a = (a << 1) ^ p;
      end else begin
        a = a << 1;
      end
    end
    return a >> sh;
  endfunction

endpackage

[rtl/ccfc_in_if.sv]
interface ccfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_frame;
  logic [7:0] message_length;

  modport source (output valid, output data_byte, output first_of_frame,
                  output message_length, input ready);
  modport sink   (input valid, input data_byte, input first_of_frame,
                  input message_length, output ready);
endinterface

[rtl/ccfc_out_if.sv]
interface ccfc_out_if;
  logic        valid;
  logic        ready;
  logic        crc_match;
  logic [31:0] computed_crc;
  logic [2:0]  crc_length;
  logic        frame_error;

  modport source (output valid, output crc_match, output computed_crc,
                  output crc_length, output frame_error, input ready);
  modport sink   (input valid, input crc_match, input computed_crc,
                  input crc_length, input frame_error, output ready);
endinterface

[rtl/configurable_crc_frame_checker_core.sv]
// Channel   Direction  Transfer when          Payload
// data_in   in         valid && ready         data_byte, first_of_frame, message_length
// result    out        valid && ready         crc_match, computed_crc, crc_length, frame_error
// cfg       in         cfg_we                 cfg_index, cfg_data
//
// One byte is taken every cycle unless data_in is stalled; the divide of a byte (eight unrolled
// XOR steps, sixteen on the first byte of a frame with a nonzero message_length, where the
// header goes first) and the state update sit between the frame state and the result register.
// A result appears in the cycle after the transfer of the byte that ends a frame or of a stray
// byte. rst is synchronous: it clears frame state and the result valid flag and loads the reset
// configuration. data_in stalls only while a held result is not taken.
module configurable_crc_frame_checker_core
  import ccfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  ccfc_in_if.sink           data_in,
  ccfc_out_if.source        result
);

  // Configuration registers
  logic [2:0]  width_bytes;
  logic [31:0] polynomial;
  logic        reflect_in;
  logic        reflect_out;

  // Frame state
  logic [31:0] remainder;
  logic [7:0]  bytes_left;
  logic        in_crc_phase;
  logic [31:0] received_crc;
  logic        frame_active;

  logic [31:0] remainder_next;
  logic [7:0]  bytes_left_next;
  logic        in_crc_phase_next;
  logic [31:0] received_crc_next;
  logic        frame_active_next;

  // Result register
  logic        out_valid;
  logic        crc_match;
  logic [31:0] computed_crc;
  logic [2:0]  crc_length;
  logic        frame_error;

  logic        res_fire;
  logic        res_match;
  logic [31:0] res_crc;
  logic        res_error;

  logic        accept;
  logic [2:0]  w;
  logic [31:0] mask;
  logic [31:0] crc_final;

  assign w      = eff_width(width_bytes);
  assign mask   = width_mask(w);
  assign accept = data_in.valid && data_in.ready;

  // Take a new byte whenever the result register is empty or being drained.
  assign data_in.ready = !out_valid || result.ready;

  // Final CRC of the stored remainder; reflect over 8*w bits.
  assign crc_final = reflect_out ? (rev32(remainder & mask) >> align_shift(w))
                                 : (remainder & mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_bytes <= WIDTH_RESET;
      polynomial  <= POLY_RESET;
      reflect_in  <= 1'b0;
      reflect_out <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH_BYTES: width_bytes <= cfg_data[2:0];
        REG_POLYNOMIAL:  polynomial  <= cfg_data;
        REG_REFLECT_IN:  reflect_in  <= cfg_data[0];
        REG_REFLECT_OUT: reflect_out <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-byte update: header divide on a frame start, then either divide the
  // data byte, shift it into the received CRC, or drop a stray byte outside a frame.
  always_comb begin
    remainder_next    = remainder;
    bytes_left_next   = bytes_left;
    in_crc_phase_next = in_crc_phase;
    received_crc_next = received_crc;
    frame_active_next = frame_active;
    res_fire          = 1'b0;
    res_match         = 1'b0;
    res_crc           = '0;
    res_error         = 1'b0;

    if (data_in.first_of_frame) begin
      frame_active_next = 1'b1;
      received_crc_next = '0;
      remainder_next    = div_byte('0, 8'(data_in.message_length + {5'b0, w}) & BYTE_MASK,
                                   w, polynomial, reflect_in);
      if (data_in.message_length != 8'd0) begin
        in_crc_phase_next = 1'b0;
        bytes_left_next   = data_in.message_length;
      end else begin
        in_crc_phase_next = 1'b1;
        bytes_left_next   = {5'b0, w};
      end
    end

    if (!data_in.first_of_frame && !frame_active) begin
      // Drop a stray byte and flag it.
      res_fire  = 1'b1;
      res_error = 1'b1;
    end else if (!in_crc_phase_next) begin
      remainder_next  = div_byte(remainder_next, data_in.data_byte, w, polynomial,
                                 reflect_in);
      bytes_left_next = bytes_left_next - 8'd1;
      if (bytes_left_next == 8'd0) begin
        in_crc_phase_next = 1'b1;
        bytes_left_next   = {5'b0, w};
      end
    end else begin
      received_crc_next = {received_crc_next[23:0], data_in.data_byte};
      bytes_left_next   = bytes_left_next - 8'd1;
      if (bytes_left_next == 8'd0) begin
        res_fire          = 1'b1;
        res_crc           = reflect_out ? (rev32(remainder_next & mask) >> align_shift(w))
                                        : (remainder_next & mask);
        res_match         = (res_crc == (received_crc_next & mask));
        frame_active_next = 1'b0;
        in_crc_phase_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder    <= '0;
      bytes_left   <= '0;
      in_crc_phase <= 1'b0;
      received_crc <= '0;
      frame_active <= 1'b0;
    end else if (accept) begin
      remainder    <= remainder_next;
      bytes_left   <= bytes_left_next;
      in_crc_phase <= in_crc_phase_next;
      received_crc <= received_crc_next;
      frame_active <= frame_active_next;
    end
  end

  // Load the result register on a finishing or stray byte; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_fire) begin
      crc_match    <= res_match;
      computed_crc <= res_crc;
      crc_length   <= w;
      frame_error  <= res_error;
    end
  end

  assign result.valid        = out_valid;
  assign result.crc_match    = crc_match;
  assign result.computed_crc = computed_crc;
  assign result.crc_length   = crc_length;
  assign result.frame_error  = frame_error;

  // Current CRC of the stored remainder, for the checks below.
  logic crc_in_range;
  assign crc_in_range = ((crc_final & ~mask) == 32'h0);

  a_phase_needs_frame: assert property (@(posedge clk) disable iff (rst)
    in_crc_phase |-> frame_active)
    else $error("CRC phase outside a frame");

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> (bytes_left != 8'd0))
    else $error("active frame with no bytes left");

  a_crc_count: assert property (@(posedge clk) disable iff (rst)
    in_crc_phase |-> (bytes_left <= 8'(MAX_WIDTH_BYTES)))
    else $error("CRC byte count above maximum width");

  a_error_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_error) |-> (!crc_match && (computed_crc == 32'h0)))
    else $error("frame error result carries a CRC");

  a_result_width: assert property (@(posedge clk) disable iff (rst)
    (accept && res_fire) |=> (out_valid && (crc_length != 3'd0) &&
                              (crc_length <= 3'(MAX_WIDTH_BYTES)) && crc_in_range))
    else $error("result width out of range");

endmodule
